>>> rtl/heater_safety_monitor_assert.svh
// Assertion macros for the heater safety monitor
`ifndef HEATER_SAFETY_MONITOR_ASSERT_SVH
`define HEATER_SAFETY_MONITOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define HSM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HSM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HSM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define HSM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/hsm_pkg.sv
`timescale 1ns / 1ps

package hsm_pkg;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] FAULT_READS = 8'd3;
    localparam logic [7:0] RECOVERY_READS = 8'd5;
    localparam logic signed [14:0] TEMP_MIN = -15'sd640;
    localparam logic signed [14:0] TEMP_MAX = 15'sd8000;
    localparam logic BATTERY_BYPASS = 1'b0;

    localparam logic [15:0] LOOP_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] CONTROL_TIMEOUT_RST = 16'd2000;
    localparam logic signed [14:0] RUNAWAY_TEMP_RST = 15'sd4800;
    localparam logic [13:0] RUNAWAY_MARGIN_RST = 14'd480;
    localparam logic [15:0] DRIVE_THRESHOLD_RST = 16'd60000;
    localparam logic [15:0] MAX_ON_TIME_RST = 16'd30000;
    localparam logic [15:0] BATTERY_CUTOFF_RST = 16'd3300;
    localparam logic [15:0] BATTERY_MIN_RST = 16'd3000;

    typedef enum logic [2:0] {
        ACT_CHECK     = 3'd0,
        ACT_LOOP_HB   = 3'd1,
        ACT_CTRL_HB   = 3'd2,
        ACT_SENSOR    = 3'd3,
        ACT_CLEAR     = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        FC_NONE     = 3'd0,
        FC_WATCHDOG = 3'd1,
        FC_THERMAL  = 3'd2,
        FC_SENSOR   = 3'd3,
        FC_BATTERY  = 3'd4
    } fault_code_t;

    typedef enum logic [2:0] {
        REG_LOOP_TIMEOUT    = 3'd0,
        REG_CONTROL_TIMEOUT = 3'd1,
        REG_RUNAWAY_TEMP    = 3'd2,
        REG_RUNAWAY_MARGIN  = 3'd3,
        REG_DRIVE_THRESHOLD = 3'd4,
        REG_MAX_ON_TIME     = 3'd5,
        REG_BATTERY_CUTOFF  = 3'd6,
        REG_BATTERY_MIN     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        battery_mv;
        logic               manual_mode;
        logic               system_enabled;
        logic [15:0]        drive_level;
        logic signed [14:0] setpoint;
        logic               reading_valid;
        logic signed [14:0] temperature;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic        battery_low;
        logic        sensor_fault;
        logic        thermal_fault;
        logic        watchdog_fault;
        fault_code_t fault_code;
        logic        safe;
    } result_t;

endpackage

>>> rtl/heater_safety_monitor.sv
`timescale 1ns / 1ps
// Channel   Direction  Word                                   Handshake
// s_        in         tuser: action; tdata: snapshot item     s_tvalid / s_tready
// m_        out        tdata: status result                   m_tvalid / m_tready
// cfg_      in         cfg_index, cfg_data                    cfg_valid / cfg_ready
//
// One word per cycle while the result side is not stalled: a word sits in the input
// register, then its state update and result land together in the state and result registers.
// aresetn is synchronous and active low; it clears state and loads default limits.
// A stalled result holds the input register; the input side stalls only when both are full.

module heater_safety_monitor #(
    parameter logic [7:0]         FAULT_READS    = hsm_pkg::FAULT_READS,
    parameter logic [7:0]         RECOVERY_READS = hsm_pkg::RECOVERY_READS,
    parameter logic signed [14:0] TEMP_MIN       = hsm_pkg::TEMP_MIN,
    parameter logic signed [14:0] TEMP_MAX       = hsm_pkg::TEMP_MAX,
    parameter logic               BATTERY_BYPASS = hsm_pkg::BATTERY_BYPASS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now_ms, temperature, reading_valid, setpoint, drive_level,
    // system_enabled, manual_mode, battery_mv, zero pad
    input  logic [hsm_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [hsm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // safe, fault_code, watchdog_fault, thermal_fault, sensor_fault, battery_low
    output logic [hsm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsm_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "heater_safety_monitor_assert.svh"

    logic [15:0]        loop_timeout_reg;
    logic [15:0]        control_timeout_reg;
    logic signed [14:0] runaway_temp_reg;
    logic [13:0]        runaway_margin_reg;
    logic [15:0]        drive_threshold_reg;
    logic [15:0]        max_on_time_reg;
    logic [15:0]        battery_cutoff_reg;
    logic [15:0]        battery_min_reg;

    logic               in_valid_reg;
    hsm_pkg::item_t     item_reg;
    hsm_pkg::action_t   action_reg;

    logic               out_valid_reg;
    hsm_pkg::result_t   result_reg;
    hsm_pkg::result_t   result_next;

    logic [31:0]        loop_mark_reg, loop_mark_next;
    logic [31:0]        control_mark_reg, control_mark_next;
    logic [31:0]        high_start_reg, high_start_next;
    logic               watchdog_reg, watchdog_next;
    logic               thermal_reg, thermal_next;
    logic               sensor_reg, sensor_next;
    logic [7:0]         bad_reads_reg, bad_reads_next;
    logic [7:0]         good_reads_reg, good_reads_next;

    logic               advance;
    logic [31:0]        loop_gap, control_gap, high_gap;
    logic signed [16:0] setpoint_limit;
    logic signed [16:0] temp_wide;
    logic               read_good;
    logic [7:0]         bad_inc, good_inc;
    logic               battery_low;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = result_reg;
    assign cfg_ready = 1'b1;

    assign loop_gap    = item_reg.now_ms - loop_mark_reg;
    assign control_gap = item_reg.now_ms - control_mark_reg;
    assign high_gap    = item_reg.now_ms - high_start_reg;
    assign setpoint_limit = $signed({{2{item_reg.setpoint[14]}}, item_reg.setpoint})
                          + $signed({3'b000, runaway_margin_reg});
    assign temp_wide   = $signed({{2{item_reg.temperature[14]}}, item_reg.temperature});
    assign read_good   = item_reg.reading_valid
                      && (item_reg.temperature >= TEMP_MIN)
                      && (item_reg.temperature <= TEMP_MAX);
    assign bad_inc     = (bad_reads_reg == 8'hFF) ? bad_reads_reg : bad_reads_reg + 8'd1;
    assign good_inc    = (good_reads_reg == 8'hFF) ? good_reads_reg : good_reads_reg + 8'd1;
    assign battery_low = item_reg.battery_mv < battery_cutoff_reg;

    always_comb begin
        loop_mark_next    = loop_mark_reg;
        control_mark_next = control_mark_reg;
        high_start_next   = high_start_reg;
        watchdog_next     = watchdog_reg;
        thermal_next      = thermal_reg;
        sensor_next       = sensor_reg;
        bad_reads_next    = bad_reads_reg;
        good_reads_next   = good_reads_reg;

        unique case (action_reg)
            hsm_pkg::ACT_CHECK: begin
                if (loop_gap > {16'd0, loop_timeout_reg}) begin
                    watchdog_next = 1'b1;
                end
                if (item_reg.system_enabled && !item_reg.manual_mode) begin
                    if (control_mark_reg == 32'd0) begin
                        control_mark_next = item_reg.now_ms;
                    end else if (control_gap > {16'd0, control_timeout_reg}) begin
                        watchdog_next = 1'b1;
                    end
                end
                if (item_reg.temperature > runaway_temp_reg) begin
                    thermal_next = 1'b1;
                end
                if (temp_wide > setpoint_limit) begin
                    thermal_next = 1'b1;
                end
                if (item_reg.drive_level > drive_threshold_reg) begin
                    if (high_start_reg == 32'd0) begin
                        high_start_next = item_reg.now_ms;
                    end else if (high_gap > {16'd0, max_on_time_reg}) begin
                        thermal_next = 1'b1;
                    end
                end else begin
                    high_start_next = 32'd0;
                end
            end
            hsm_pkg::ACT_LOOP_HB: begin
                loop_mark_next = item_reg.now_ms;
            end
            hsm_pkg::ACT_CTRL_HB: begin
                control_mark_next = item_reg.now_ms;
            end
            hsm_pkg::ACT_SENSOR: begin
                if (item_reg.battery_mv >= battery_min_reg) begin
                    if (read_good) begin
                        good_reads_next = good_inc;
                        bad_reads_next  = 8'd0;
                        if (good_inc >= RECOVERY_READS) begin
                            sensor_next = 1'b0;
                        end
                    end else begin
                        bad_reads_next  = bad_inc;
                        good_reads_next = 8'd0;
                        if (bad_inc >= FAULT_READS) begin
                            sensor_next = 1'b1;
                        end
                    end
                end
            end
            hsm_pkg::ACT_CLEAR: begin
                watchdog_next   = 1'b0;
                thermal_next    = 1'b0;
                sensor_next     = 1'b0;
                high_start_next = 32'd0;
                bad_reads_next  = 8'd0;
                good_reads_next = 8'd0;
            end
            default: begin
            end
        endcase

        result_next.battery_low    = battery_low;
        result_next.sensor_fault   = sensor_next;
        result_next.thermal_fault  = thermal_next;
        result_next.watchdog_fault = watchdog_next;
        result_next.safe = !watchdog_next && !thermal_next && !sensor_next
                        && (!battery_low || BATTERY_BYPASS);
        if (watchdog_next) begin
            result_next.fault_code = hsm_pkg::FC_WATCHDOG;
        end else if (thermal_next) begin
            result_next.fault_code = hsm_pkg::FC_THERMAL;
        end else if (sensor_next) begin
            result_next.fault_code = hsm_pkg::FC_SENSOR;
        end else if (battery_low && !BATTERY_BYPASS) begin
            result_next.fault_code = hsm_pkg::FC_BATTERY;
        end else begin
            result_next.fault_code = hsm_pkg::FC_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_timeout_reg    <= hsm_pkg::LOOP_TIMEOUT_RST;
            control_timeout_reg <= hsm_pkg::CONTROL_TIMEOUT_RST;
            runaway_temp_reg    <= hsm_pkg::RUNAWAY_TEMP_RST;
            runaway_margin_reg  <= hsm_pkg::RUNAWAY_MARGIN_RST;
            drive_threshold_reg <= hsm_pkg::DRIVE_THRESHOLD_RST;
            max_on_time_reg     <= hsm_pkg::MAX_ON_TIME_RST;
            battery_cutoff_reg  <= hsm_pkg::BATTERY_CUTOFF_RST;
            battery_min_reg     <= hsm_pkg::BATTERY_MIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (hsm_pkg::reg_idx_t'(cfg_index))
                hsm_pkg::REG_LOOP_TIMEOUT:    loop_timeout_reg    <= cfg_data;
                hsm_pkg::REG_CONTROL_TIMEOUT: control_timeout_reg <= cfg_data;
                hsm_pkg::REG_RUNAWAY_TEMP:    runaway_temp_reg    <= $signed(cfg_data[14:0]);
                hsm_pkg::REG_RUNAWAY_MARGIN:  runaway_margin_reg  <= cfg_data[13:0];
                hsm_pkg::REG_DRIVE_THRESHOLD: drive_threshold_reg <= cfg_data;
                hsm_pkg::REG_MAX_ON_TIME:     max_on_time_reg     <= cfg_data;
                hsm_pkg::REG_BATTERY_CUTOFF:  battery_cutoff_reg  <= cfg_data;
                hsm_pkg::REG_BATTERY_MIN:     battery_min_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            loop_mark_reg    <= 32'd0;
            control_mark_reg <= 32'd0;
            high_start_reg   <= 32'd0;
            watchdog_reg     <= 1'b0;
            thermal_reg      <= 1'b0;
            sensor_reg       <= 1'b0;
            bad_reads_reg    <= 8'd0;
            good_reads_reg   <= 8'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                item_reg     <= hsm_pkg::item_t'(s_tdata[$bits(hsm_pkg::item_t)-1:0]);
                action_reg   <= hsm_pkg::action_t'(s_tuser);
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                result_reg       <= result_next;
                loop_mark_reg    <= loop_mark_next;
                control_mark_reg <= control_mark_next;
                high_start_reg   <= high_start_next;
                watchdog_reg     <= watchdog_next;
                thermal_reg      <= thermal_next;
                sensor_reg       <= sensor_next;
                bad_reads_reg    <= bad_reads_next;
                good_reads_reg   <= good_reads_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `HSM_ASSERT_IMP(a_reads_exclusive, aclk, aresetn,
        bad_reads_reg != 8'd0, good_reads_reg == 8'd0, "both read counts nonzero")
    `HSM_ASSERT_NXT(a_clear_drops, aclk, aresetn,
        advance && (action_reg == hsm_pkg::ACT_CLEAR),
        !watchdog_reg && !thermal_reg && !sensor_reg && (high_start_reg == 32'd0),
        "clear left a latch set")
    `HSM_ASSERT_IMP(a_safe_code, aclk, aresetn,
        out_valid_reg,
        result_reg.safe == (result_reg.fault_code == hsm_pkg::FC_NONE),
        "safe flag disagrees with fault code")
    `HSM_ASSERT_IMP(a_watchdog_first, aclk, aresetn,
        out_valid_reg && result_reg.watchdog_fault,
        result_reg.fault_code == hsm_pkg::FC_WATCHDOG,
        "watchdog fault not reported first")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hsm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 48;
    localparam int SETTLE_CYCLES = 4;

    class heater_status_predictor;
        logic [15:0]        loop_timeout;
        logic [15:0]        control_timeout;
        logic signed [14:0] runaway_temp;
        logic [13:0]        runaway_margin;
        logic [15:0]        drive_threshold;
        logic [15:0]        max_on_time;
        logic [15:0]        battery_cutoff;
        logic [15:0]        battery_min;
        logic [31:0]        loop_mark;
        logic [31:0]        control_mark;
        logic [31:0]        high_drive_start;
        bit                 wd_latch;
        bit                 th_latch;
        bit                 sn_latch;
        logic [7:0]         bad_reads;
        logic [7:0]         good_reads;
        result_t            expected_status[$];
        int                 errors;

        function new();
            loop_timeout = LOOP_TIMEOUT_RST;
            control_timeout = CONTROL_TIMEOUT_RST;
            runaway_temp = RUNAWAY_TEMP_RST;
            runaway_margin = RUNAWAY_MARGIN_RST;
            drive_threshold = DRIVE_THRESHOLD_RST;
            max_on_time = MAX_ON_TIME_RST;
            battery_cutoff = BATTERY_CUTOFF_RST;
            battery_min = BATTERY_MIN_RST;
            loop_mark = '0;
            control_mark = '0;
            high_drive_start = '0;
            wd_latch = 0;
            th_latch = 0;
            sn_latch = 0;
            bad_reads = '0;
            good_reads = '0;
            errors = 0;
        endfunction

        function void set_limit(reg_idx_t idx, logic [15:0] value);
            case (idx)
                REG_LOOP_TIMEOUT:    loop_timeout = value;
                REG_CONTROL_TIMEOUT: control_timeout = value;
                REG_RUNAWAY_TEMP:    runaway_temp = value[14:0];
                REG_RUNAWAY_MARGIN:  runaway_margin = value[13:0];
                REG_DRIVE_THRESHOLD: drive_threshold = value;
                REG_MAX_ON_TIME:     max_on_time = value;
                REG_BATTERY_CUTOFF:  battery_cutoff = value;
                REG_BATTERY_MIN:     battery_min = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_word(logic [2:0] act, item_t it);
            logic [31:0] now;
            int          temp;
            int          setpt;
            bit          bat_low;
            result_t     r;
            now = it.now_ms;
            temp = $signed(it.temperature);
            setpt = $signed(it.setpoint);
            case (act)
                ACT_CHECK: begin
                    if (32'(now - loop_mark) > 32'(loop_timeout))
                        wd_latch = 1;
                    if (it.system_enabled && !it.manual_mode) begin
                        if (control_mark == '0)
                            control_mark = now;
                        else if (32'(now - control_mark) > 32'(control_timeout))
                            wd_latch = 1;
                    end
                    if (temp > int'(runaway_temp))
                        th_latch = 1;
                    if (temp > setpt + int'(runaway_margin))
                        th_latch = 1;
                    if (it.drive_level > drive_threshold) begin
                        if (high_drive_start == '0)
                            high_drive_start = now;
                        else if (32'(now - high_drive_start) > 32'(max_on_time))
                            th_latch = 1;
                    end else begin
                        high_drive_start = '0;
                    end
                end
                ACT_LOOP_HB: loop_mark = now;
                ACT_CTRL_HB: control_mark = now;
                ACT_SENSOR: begin
                    if (it.battery_mv >= battery_min) begin
                        if (it.reading_valid && temp >= TEMP_MIN && temp <= TEMP_MAX) begin
                            if (good_reads != 8'hFF)
                                good_reads++;
                            bad_reads = '0;
                            if (sn_latch && good_reads >= RECOVERY_READS)
                                sn_latch = 0;
                        end else begin
                            if (bad_reads != 8'hFF)
                                bad_reads++;
                            good_reads = '0;
                            if (!sn_latch && bad_reads >= FAULT_READS)
                                sn_latch = 1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    wd_latch = 0;
                    th_latch = 0;
                    sn_latch = 0;
                    high_drive_start = '0;
                    bad_reads = '0;
                    good_reads = '0;
                end
                default: ;
            endcase
            bat_low = it.battery_mv < battery_cutoff;
            r.safe = !wd_latch && !th_latch && !sn_latch && (!bat_low || BATTERY_BYPASS);
            if (wd_latch)
                r.fault_code = FC_WATCHDOG;
            else if (th_latch)
                r.fault_code = FC_THERMAL;
            else if (sn_latch)
                r.fault_code = FC_SENSOR;
            else if (bat_low && !BATTERY_BYPASS)
                r.fault_code = FC_BATTERY;
            else
                r.fault_code = FC_NONE;
            r.watchdog_fault = wd_latch;
            r.thermal_fault = th_latch;
            r.sensor_fault = sn_latch;
            r.battery_low = bat_low;
            expected_status.push_back(r);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_status(result_t got);
            result_t want;
            if (expected_status.size() == 0) begin
                $error("status word %h with none expected", got);
                errors++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("safe", want.safe, got.safe);
            compare_field("fault_code", want.fault_code, got.fault_code);
            compare_field("watchdog_fault", want.watchdog_fault, got.watchdog_fault);
            compare_field("thermal_fault", want.thermal_fault, got.thermal_fault);
            compare_field("sensor_fault", want.sensor_fault, got.sensor_fault);
            compare_field("battery_low", want.battery_low, got.battery_low);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    heater_status_predictor sb;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req = 0;
    int          hold_left = 0;
    int          stuck_cycles = 0;
    logic [31:0] clock_ms = '0;
    logic [15:0] drive_now = '0;

    heater_safety_monitor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_status(result_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic [14:0] near15(int center, int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v < -16384)
            v = -16384;
        if (v > 16383)
            v = 16383;
        return v[14:0];
    endfunction

    function automatic logic [15:0] near16(int center, int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    function automatic void draw_word(output logic [2:0] act, output item_t it);
        int pick;
        pick = $urandom_range(99);
        if (pick < 36)
            act = ACT_CHECK;
        else if (pick < 56)
            act = ACT_LOOP_HB;
        else if (pick < 68)
            act = ACT_CTRL_HB;
        else if (pick < 90)
            act = ACT_SENSOR;
        else if (pick < 98)
            act = ACT_CLEAR;
        else
            act = 3'($urandom_range(7));

        pick = $urandom_range(99);
        if (pick < 3)
            clock_ms = $urandom;
        else if (pick < 5)
            clock_ms = '0;
        else if (pick < 15)
            clock_ms += $urandom_range(70000);
        else
            clock_ms += $urandom_range(sb.loop_timeout / 3 + 3);
        it.now_ms = clock_ms;

        if ($urandom_range(99) < 70)
            it.setpoint = near15(1600, 1600);
        else
            it.setpoint = 15'($urandom);
        pick = $urandom_range(99);
        if (pick < 45)
            it.temperature = near15($signed(it.setpoint), 700);
        else if (pick < 60)
            it.temperature = near15($signed(sb.runaway_temp), 4);
        else if (pick < 68)
            it.temperature = near15(TEMP_MAX, 2);
        else if (pick < 76)
            it.temperature = near15(TEMP_MIN, 2);
        else
            it.temperature = 15'($urandom);
        it.reading_valid = ($urandom_range(99) < 85);

        pick = $urandom_range(99);
        if (pick < 4)
            drive_now = near16(sb.drive_threshold, 4);
        else if (pick < 6)
            drive_now = 16'hFFFF;
        else if (pick < 9)
            drive_now = 16'($urandom);
        it.drive_level = drive_now;

        it.system_enabled = ($urandom_range(99) < 80);
        it.manual_mode = ($urandom_range(99) < 20);
        pick = $urandom_range(99);
        if (pick < 40)
            it.battery_mv = near16(sb.battery_cutoff, 50);
        else if (pick < 70)
            it.battery_mv = near16(sb.battery_min, 50);
        else
            it.battery_mv = 16'($urandom);
    endfunction

    task automatic send_word(input logic [2:0] act, input item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= S_TDATA_W'(it);
        do @(posedge aclk); while (!s_tready);
        sb.note_word(act, it);
        @(negedge aclk);
    endtask

    task automatic send_snapshot(input logic [2:0] act, input logic [31:0] now, input int temp,
                                 input bit valid, input int setpt, input logic [15:0] drive,
                                 input bit en, input bit man, input logic [15:0] bat);
        item_t it;
        it.now_ms = now;
        it.temperature = 15'(temp);
        it.reading_valid = valid;
        it.setpoint = 15'(setpt);
        it.drive_level = drive;
        it.system_enabled = en;
        it.manual_mode = man;
        it.battery_mv = bat;
        send_word(act, it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input reg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_limit(idx, value);
        @(negedge aclk);
    endtask

    task automatic load_limits(input logic [15:0] lt, ct, rt, rm, dt, mo, bc, bm);
        write_limit(REG_LOOP_TIMEOUT, lt);
        write_limit(REG_CONTROL_TIMEOUT, ct);
        write_limit(REG_RUNAWAY_TEMP, rt);
        write_limit(REG_RUNAWAY_MARGIN, rm);
        write_limit(REG_DRIVE_THRESHOLD, dt);
        write_limit(REG_MAX_ON_TIME, mo);
        write_limit(REG_BATTERY_CUTOFF, bc);
        write_limit(REG_BATTERY_MIN, bm);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_limits();
        load_limits(16'($urandom_range(3000, 200)), 16'($urandom_range(5000, 200)),
                    16'(int'($urandom_range(9000)) - 1000), 16'($urandom_range(2000)),
                    16'($urandom), 16'($urandom_range(40000, 1000)),
                    16'($urandom_range(3600, 2800)), 16'($urandom_range(3400, 2500)));
    endtask

    task automatic run_phase(input int count, input int tx_pct, input int rx_pct,
                             input bit hold_off);
        logic [2:0] act;
        item_t      it;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            if (hold_off && i == count / 4)
                hold_req = 1;
            if (i == count / 2)
                drain();
            draw_word(act, it);
            send_word(act, it);
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 17;
        rx_idle_pct = 59;

        send_snapshot(ACT_CHECK,   32'd0,     0,     1, 0,     16'd0,     1, 0, 16'd3300);
        send_snapshot(ACT_CHECK,   32'd1000,  0,     1, 0,     16'hFFFF,  1, 0, 16'd3299);
        send_snapshot(ACT_CHECK,   32'd1001,  0,     1, 0,     16'hFFFF,  1, 0, 16'd4000);
        send_snapshot(ACT_CLEAR,   32'd1002,  0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_LOOP_HB, 32'd31000, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_CTRL_HB, 32'd31000, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_CHECK,   32'd31001, 4800,  1, 4320,  16'hFFFF,  1, 0, 16'd4000);
        send_snapshot(ACT_LOOP_HB, 32'd61000, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_CTRL_HB, 32'd61000, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_CHECK,   32'd61001, 1000,  1, 1000,  16'hFFFF,  1, 0, 16'd4000);
        send_snapshot(ACT_CHECK,   32'd61002, 16383, 1, 16383, 16'hFFFF,  1, 0, 16'd4000);
        send_snapshot(ACT_CLEAR,   32'd61003, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_CHECK,   32'd61004, 481,   1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_CLEAR,   32'd61005, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_LOOP_HB, 32'd63006, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_CHECK,   32'd63006, -16384, 1, -16384, 16'd0,   1, 0, 16'd4000);
        send_snapshot(ACT_CLEAR,   32'd63007, 0,     1, 0,     16'd0,     1, 0, 16'd4000);
        send_snapshot(ACT_SENSOR,  32'd63008, 0,     0, 0,     16'd0,     1, 0, 16'd3000);
        send_snapshot(ACT_SENSOR,  32'd63009, 8001,  1, 0,     16'd0,     1, 0, 16'd3000);
        send_snapshot(ACT_SENSOR,  32'd63010, -641,  1, 0,     16'd0,     1, 0, 16'd3000);
        send_snapshot(ACT_SENSOR,  32'd63011, 0,     0, 0,     16'd0,     1, 0, 16'd2999);
        send_snapshot(ACT_SENSOR,  32'd63012, -640,  1, 0,     16'd0,     1, 0, 16'hFFFF);
        send_snapshot(ACT_SENSOR,  32'd63013, 8000,  1, 0,     16'd0,     1, 0, 16'hFFFF);
        send_snapshot(ACT_SENSOR,  32'd63014, 0,     1, 0,     16'd0,     1, 0, 16'hFFFF);
        send_snapshot(ACT_SENSOR,  32'd63015, 0,     1, 0,     16'd0,     1, 0, 16'hFFFF);
        send_snapshot(ACT_SENSOR,  32'd63016, 0,     1, 0,     16'd0,     1, 0, 16'hFFFF);
        send_snapshot(3'd7,        32'd63017, 0,     1, 0,     16'd0,     1, 0, 16'd0);
        send_snapshot(ACT_LOOP_HB, 32'hFFFFFF00, 0,  1, 0,     16'd0,     1, 1, 16'd4000);
        send_snapshot(ACT_CHECK,   32'h00000100, 0,  1, 0,     16'hFFFF,  1, 1, 16'd4000);
        drain();

        clock_ms = $urandom;
        load_random_limits();
        run_phase(270, 17, 59, 0);

        load_limits(16'd0, 16'd0, 16'h4000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(270, 59, 17, 0);

        load_limits(16'hFFFF, 16'hFFFF, 16'h3FFF, 16'h3FFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF);
        run_phase(140, 0, 0, 1);

        load_random_limits();
        run_phase(140, 0, 0, 0);

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
